// File: hdl/i2a_pkg.sv
// Package for the int64 to decimal ASCII converter.
// Holds the shared widths, ASCII codes and the double-dabble step function.
// No dependencies.
`default_nettype none
package i2a_pkg;

  localparam int unsigned ValueW       = 64;
  localparam int unsigned CharW        = 8;
  localparam int unsigned DigitW       = 4;
  // A signed 64-bit magnitude never exceeds 2^63, which has 19 decimal digits.
  localparam int unsigned BcdDigits    = 19;
  localparam int unsigned BcdW         = BcdDigits * DigitW;
  localparam int unsigned IdxW         = $clog2(BcdDigits + 1);
  localparam int unsigned StepsPerStg  = 8;
  localparam int unsigned NumStages    = ValueW / StepsPerStg;
  localparam int unsigned DefMaxDigits = 19;

  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  typedef logic [BcdW-1:0] bcd_t;

  // One double-dabble step: add three to every digit of five or more,
  // then shift the next binary bit in at the bottom.
  function automatic bcd_t dabble_step(input bcd_t bcd, input logic bit_in);
    bcd_t adj;
    adj = bcd;
    for (int d = 0; d < BcdDigits; d++) begin
      if (adj[d*DigitW +: DigitW] >= 4'd5) begin
        adj[d*DigitW +: DigitW] = adj[d*DigitW +: DigitW] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], bit_in};
  endfunction

endpackage
`default_nettype wire

// File: hdl/int64_to_decimal_ascii_core.sv
// Top level of the signed 64-bit integer to decimal ASCII converter.
// Depends on i2a_pkg, i2a_dabble_stage and i2a_serializer.
//
// Each accepted 64-bit value yields its decimal text, one character per
// output beat, sign first, with last_o on the final character. The text
// of a value is 1 to 20 characters long; the output channel sets the
// rate. The conversion runs through a nine-stage pipeline (a negation
// stage and eight double-dabble stages of eight bits each), and later
// values convert while earlier text is still being sent.
`default_nettype none
module int64_to_decimal_ascii_core #(
  parameter int unsigned MAX_DIGITS = i2a_pkg::DefMaxDigits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [i2a_pkg::ValueW-1:0]  value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [i2a_pkg::CharW-1:0]        out_char_o,
  output logic                             last_o
);
  import i2a_pkg::*;

  logic              adv;
  logic              take;
  logic              v0_q;
  logic              neg0_q;
  logic [ValueW-1:0] mag0_q;

  logic              sv [NumStages+1];
  logic              sn [NumStages+1];
  bcd_t              sb [NumStages+1];
  logic [ValueW-1:0] sm [NumStages+1];

  // The whole pipeline moves unless a finished number waits at its end.
  assign adv        = !(sv[NumStages] && !take);
  assign in_stall_o = !adv;

  // Sign and magnitude stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg0_q <= value_i[ValueW-1];
      mag0_q <= value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
    end
  end

  assign sv[0] = v0_q;
  assign sn[0] = neg0_q;
  assign sb[0] = '0;
  assign sm[0] = mag0_q;

  // Binary to BCD conversion stages.
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    i2a_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv[g]),
      .neg_i   (sn[g]),
      .bcd_i   (sb[g]),
      .bin_i   (sm[g]),
      .valid_o (sv[g+1]),
      .neg_o   (sn[g+1]),
      .bcd_o   (sb[g+1]),
      .bin_o   (sm[g+1])
    );
  end

  // Character output.
  i2a_serializer #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sv[NumStages]),
    .neg_i       (sn[NumStages]),
    .bcd_i       (sb[NumStages]),
    .take_o      (take),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

// File: hdl/i2a_dabble_stage.sv
// One register stage of the binary to BCD pipeline: eight dabble steps.
// Depends on i2a_pkg.
`default_nettype none
module i2a_dabble_stage (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic                        neg_i,
  input  wire i2a_pkg::bcd_t               bcd_i,
  input  wire logic [i2a_pkg::ValueW-1:0]  bin_i,
  output logic                             valid_o,
  output logic                             neg_o,
  output i2a_pkg::bcd_t                    bcd_o,
  output logic [i2a_pkg::ValueW-1:0]       bin_o
);
  import i2a_pkg::*;

  logic              valid_q;
  logic              neg_q;
  bcd_t              bcd_q, bcd_d;
  logic [ValueW-1:0] bin_q, bin_d;

  // Eight steps take the top eight bits of the remaining binary word.
  always_comb begin
    bcd_d = bcd_i;
    for (int s = 0; s < StepsPerStg; s++) begin
      bcd_d = dabble_step(bcd_d, bin_i[ValueW-1-s]);
    end
    bin_d = {bin_i[ValueW-StepsPerStg-1:0], {StepsPerStg{1'b0}}};
  end

  // Valid bit under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= neg_i;
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end
  end

  assign valid_o = valid_q;
  assign neg_o   = neg_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;

endmodule
`default_nettype wire

// File: hdl/i2a_serializer.sv
// Character serializer: takes a converted BCD number and emits its text.
// Depends on i2a_pkg.
`default_nettype none
module i2a_serializer #(
  parameter int unsigned MAX_DIGITS = i2a_pkg::DefMaxDigits
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic                       neg_i,
  input  wire i2a_pkg::bcd_t              bcd_i,
  output logic                            take_o,
  output logic [i2a_pkg::CharW-1:0]       out_char_o,
  output logic                            last_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i
);
  import i2a_pkg::*;

  localparam logic [IdxW-1:0] MaxIdx = IdxW'(MAX_DIGITS - 1);

  logic                busy_q, busy_d;
  logic                neg_q, neg_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [DigitW-1:0]   dig_q [BcdDigits];
  logic [IdxW-1:0]     top_idx;
  logic [IdxW-1:0]     start_idx;
  logic                beat;
  logic                load;

  // Index of the highest nonzero digit, zero for a zero value.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < BcdDigits; d++) begin
      if (bcd_i[d*DigitW +: DigitW] != '0) begin
        top_idx = IdxW'(d);
      end
    end
    start_idx = (top_idx > MaxIdx) ? MaxIdx : top_idx;
  end

  assign beat   = busy_q && !out_stall_i;
  assign take_o = !busy_q || (beat && last_o);
  assign load   = take_o && valid_i;

  // Next-state logic for the emit counter.
  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      neg_d  = neg_i;
      idx_d  = start_idx;
    end else if (beat) begin
      if (neg_q) begin
        neg_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
      idx_q  <= idx_d;
    end
  end

  // Digit holding registers, loaded with each new number.
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int d = 0; d < BcdDigits; d++) begin
        dig_q[d] <= bcd_i[d*DigitW +: DigitW];
      end
    end
  end

  // Output beat: the sign first, then digits from the top down.
  assign out_valid_o = busy_q;
  assign out_char_o  = neg_q ? CharMinus : (CharZero + CharW'(dig_q[idx_q]));
  assign last_o      = !neg_q && (idx_q == '0);

endmodule
`default_nettype wire

// File: hdl/int64_to_decimal_ascii_core_chk.sv
// Port-level checker for the int64 to decimal ASCII converter, and its bind.
// Depends on i2a_pkg and int64_to_decimal_ascii_core.
`default_nettype none
module int64_to_decimal_ascii_core_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [i2a_pkg::CharW-1:0]   out_char_o,
  input wire logic                        last_o
);
  import i2a_pkg::*;

  // A stalled output beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) && $stable(last_o))
    else $error("stalled output beat changed");

  // A minus sign is never the final character.
  a_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_char_o == CharMinus) |-> !last_o)
    else $error("minus sign flagged last");

  // Every character is a sign or a digit.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o == CharMinus) ||
                    ((out_char_o >= CharZero) && (out_char_o <= CharZero + 8'd9)))
    else $error("character outside sign and digits");

  // Text continues without a gap, and only with digits, until the last beat.
  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (out_char_o >= CharZero) && (out_char_o <= CharZero + 8'd9))
    else $error("text broken before last character");

endmodule

bind int64_to_decimal_ascii_core int64_to_decimal_ascii_core_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_char_o  (out_char_o),
  .last_o      (last_o)
);
`default_nettype wire
